### sv/aes128_cmac_engine_top_assert.svh
// Assertion macros for the CMAC engine top level.
`ifndef AES128_CMAC_ENGINE_TOP_ASSERT_SVH
`define AES128_CMAC_ENGINE_TOP_ASSERT_SVH
// Condition that must hold at every clock edge outside reset.
`define CMAC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define CMAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

### sv/cmac_pkg.sv
// Shared types, AES tables and round functions for the CMAC engine.
package cmac_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [63:0] mac_high;
    logic [63:0] mac_low;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } enc_stat_t;

  typedef enum logic [2:0] {
    S_IDLE, S_KCHK, S_DERIVE, S_ACHK, S_ABSORB, S_INS, S_FINAL
  } seq_state_e;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;
  localparam logic [3:0] LAST_ROUND   = 4'd10;
  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [7:0] DBL_POLY     = 8'h87;
  localparam logic [7:0] XT_POLY      = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? XT_POLY : 8'h00);
  endfunction

  // One step of the key schedule: round key of round rnd from that of rnd-1.
  function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [3:0] rnd);
    logic [31:0] w3, t, n0, n1, n2, n3;
    w3 = rk[31:0];
    t = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]} ^
        {rcon(rnd), 24'h0};
    n0 = rk[127:96] ^ t;
    n1 = rk[95:64] ^ n0;
    n2 = rk[63:32] ^ n1;
    n3 = rk[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // SubBytes, ShiftRows, MixColumns (skipped on the last round), AddRoundKey.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic fin);
    logic [7:0] t [16];
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (fin) begin
        o[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127-32*c -: 32] = {a0 ^ al ^ xt(a0 ^ a1), a1 ^ al ^ xt(a1 ^ a2),
                             a2 ^ al ^ xt(a2 ^ a3), a3 ^ al ^ xt(a3 ^ a0)};
      end
    end
    return o ^ rk;
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] a);
    return {a[126:0], 1'b0} ^ {120'h0, (a[127] ? DBL_POLY : 8'h00)};
  endfunction

endpackage

### sv/cmac_aes_core.sv
// Iterative AES-128 encryptor: one round per cycle, round keys made on the fly.
module cmac_aes_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [127:0]         block_i,
  input  logic [127:0]         key_i,
  output cmac_pkg::enc_stat_t  stat_o,
  output logic [127:0]         result_o
);
  import cmac_pkg::*;

  logic         busy_q, busy_d, done_q, done_d;
  logic [3:0]   round_q, round_d;
  logic [127:0] state_q, state_d, rk_q, rk_d, rk_next;

  assign rk_next = key_step(rk_q, round_q);

  always_comb begin
    busy_d  = busy_q;
    done_d  = done_q;
    round_d = round_q;
    state_d = state_q;
    rk_d    = rk_q;
    if (start_i) begin
      busy_d  = 1'b1;
      done_d  = 1'b0;
      round_d = 4'd1;
      state_d = block_i ^ key_i;
      rk_d    = key_i;
    end else if (busy_q) begin
      rk_d    = rk_next;
      state_d = aes_round(state_q, rk_next, round_q == LAST_ROUND);
      round_d = round_q + 4'd1;
      if (round_q == LAST_ROUND) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= 4'd0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    rk_q    <= rk_d;
  end

  assign stat_o   = '{busy: busy_q, done: done_q};
  assign result_o = state_q;

endmodule

### sv/aes128_cmac_engine_top.sv
// AES-128 CMAC engine top level: chunk sequencer, key/subkey store and tag register.
// Usage: write key_high (index 0) and key_low (index 1) while idle, then stream a message
// as 8-byte chunks, earliest byte in bits 63:56, last=1 on the final chunk with
// byte_count giving its valid leading bytes (0..8, larger counts as 8). Non-last chunks
// always count as 8 bytes. One tag transfer follows each last chunk. Each chunk passes
// through the sequencer states and, where it needs them, AES passes on the single
// iterative AES core (one round per cycle): a subkey derivation at the first chunk of a
// message after a key change, an absorb when a full 16-byte block is held and more data
// follows, and the final pass on the last chunk. in_ready_o is high only while the
// sequencer is idle; a finished tag waits in its own output register, so the next
// message may start before it is taken.
module aes128_cmac_engine_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [0:0]     cfg_idx_i,
  input  logic [63:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cmac_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cmac_pkg::out_t out_data_o
);
  import cmac_pkg::*;

  seq_state_e   state_q, state_d;
  logic [63:0]  key_hi_q, key_lo_q;
  logic         keys_ready_q, keys_ready_d;
  logic [127:0] base_key_q, base_key_d, k1_q, k1_d, k2_q, k2_d;
  logic [127:0] chain_q, chain_d, buf_q, buf_d;
  logic [4:0]   cnt_q, cnt_d;
  in_t          item_q;
  logic         out_valid_q, out_valid_d;
  out_t         out_q, out_d;

  // AES core hookup
  logic         enc_start;
  logic [127:0] enc_block, enc_key, enc_res;
  enc_stat_t    enc_stat;

  // chunk decode
  logic [3:0]   n_bytes;
  logic [63:0]  word_masked;
  logic [127:0] buf_ins, buf_fin;
  logic [4:0]   cnt_ins;

  cmac_aes_core u_aes (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (enc_start),
    .block_i  (enc_block),
    .key_i    (enc_key),
    .stat_o   (enc_stat),
    .result_o (enc_res)
  );

  // effective byte count: 8 unless last, saturated at 8
  always_comb begin
    if (!item_q.last || item_q.byte_count > 4'd8) begin
      n_bytes = 4'd8;
    end else begin
      n_bytes = item_q.byte_count;
    end
    word_masked = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < int'(n_bytes)) begin
        word_masked[63-8*b -: 8] = item_q.data_word[63-8*b -: 8];
      end
    end
    buf_ins = buf_q;
    if (n_bytes != 4'd0) begin
      if (cnt_q >= 5'd8) begin
        buf_ins[63:0] = word_masked;
      end else begin
        buf_ins[127:64] = word_masked;
      end
    end
    cnt_ins = cnt_q + {1'b0, n_bytes};
    // final block: complete takes K1, short one gets 0x80 padding and K2
    if (cnt_ins >= 5'd16) begin
      buf_fin = buf_ins ^ k1_q;
    end else begin
      buf_fin = buf_ins;
      for (int i = 0; i < 16; i++) begin
        if (5'(i) == cnt_ins) begin
          buf_fin[127-8*i -: 8] = buf_ins[127-8*i -: 8] | PAD_BYTE;
        end
      end
      buf_fin = buf_fin ^ k2_q;
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    keys_ready_d = keys_ready_q;
    base_key_d   = base_key_q;
    k1_d         = k1_q;
    k2_d         = k2_q;
    chain_d      = chain_q;
    buf_d        = buf_q;
    cnt_d        = cnt_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    enc_start    = 1'b0;
    enc_block    = chain_q ^ buf_q;
    enc_key      = base_key_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_KCHK;
        end
      end
      S_KCHK: begin
        // new key: derive L = AES(K, 0) first
        if (cnt_q == 5'd0 && !keys_ready_q) begin
          enc_start  = 1'b1;
          enc_block  = '0;
          enc_key    = {key_hi_q, key_lo_q};
          base_key_d = {key_hi_q, key_lo_q};
          state_d    = S_DERIVE;
        end else begin
          state_d = S_ACHK;
        end
      end
      S_DERIVE: begin
        if (enc_stat.done) begin
          k1_d         = dbl(enc_res);
          k2_d         = dbl(dbl(enc_res));
          keys_ready_d = 1'b1;
          state_d      = S_ACHK;
        end
      end
      S_ACHK: begin
        // held full block is absorbed only once more data exists
        if (cnt_q >= 5'd16 && (n_bytes != 4'd0 || !item_q.last)) begin
          enc_start = 1'b1;
          state_d   = S_ABSORB;
        end else begin
          state_d = S_INS;
        end
      end
      S_ABSORB: begin
        if (enc_stat.done) begin
          chain_d = enc_res;
          buf_d   = '0;
          cnt_d   = 5'd0;
          state_d = S_INS;
        end
      end
      S_INS: begin
        if (!item_q.last) begin
          buf_d   = buf_ins;
          cnt_d   = cnt_ins;
          state_d = S_IDLE;
        end else begin
          enc_start = 1'b1;
          enc_block = chain_q ^ buf_fin;
          state_d   = S_FINAL;
        end
      end
      S_FINAL: begin
        // wait for the tag register to be free
        if (enc_stat.done && (!out_valid_q || out_ready_i)) begin
          out_d       = '{mac_high: enc_res[127:64], mac_low: enc_res[63:0]};
          out_valid_d = 1'b1;
          chain_d     = '0;
          buf_d       = '0;
          cnt_d       = 5'd0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // key writes must arrive only while idle; the user is bound, the block does not enforce it
    if (cfg_we_i) begin
      keys_ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      keys_ready_q <= 1'b0;
      chain_q      <= '0;
      buf_q        <= '0;
      cnt_q        <= 5'd0;
      out_valid_q  <= 1'b0;
      key_hi_q     <= '0;
      key_lo_q     <= '0;
    end else begin
      state_q      <= state_d;
      keys_ready_q <= keys_ready_d;
      chain_q      <= chain_d;
      buf_q        <= buf_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == REG_KEY_HIGH) begin
        key_hi_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_KEY_LOW) begin
        key_lo_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_key_q <= base_key_d;
    k1_q       <= k1_d;
    k2_q       <= k2_d;
    out_q      <= out_d;
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "aes128_cmac_engine_top_assert.svh"

  `CMAC_ASSERT(a_ready_core_idle, !(in_ready_o && enc_stat.busy), "ready while AES core busy")
  `CMAC_ASSERT(a_cnt_range, cnt_q <= 5'd16, "buffered byte count above one block")
  `CMAC_ASSERT_NEXT(a_busy_after_xfer, in_valid_i && in_ready_o, !in_ready_o, "ready after transfer")
  `CMAC_ASSERT_NEXT(a_final_done, state_q == S_FINAL && state_d == S_IDLE, out_valid_o, "tag lost")

endmodule

### sim/tb_top.sv
// Testbench for the AES-128 CMAC engine: directed and random chunked messages checked against a CMAC predictor.
`timescale 1ns / 100ps

module tb_top;
  import cmac_pkg::*;

  // Software CMAC model; keeps its own key, chain and buffer.
  class tag_scoreboard;
    logic [63:0]  key_hi, key_lo;
    logic [31:0]  rk [44];
    logic [127:0] k1, k2, chain, buffer;
    int unsigned  fill;
    bit           derived;
    logic [127:0] pending_tags [$];
    int           errors;

    function void reset_state();
      key_hi = '0; key_lo = '0; chain = '0; buffer = '0; fill = 0; derived = 0;
      errors = 0;
      pending_tags.delete();
    endfunction

    // A write to either key half forces a new derivation at the next message start.
    function void write_key(logic [0:0] idx, logic [63:0] val);
      if (idx == REG_KEY_HIGH) key_hi = val;
      else key_lo = val;
      derived = 0;
    endfunction

    function logic [7:0] gmul2(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function logic [127:0] aes_block_enc(logic [127:0] blk);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
      for (int rnd = 0; rnd <= 10; rnd++) begin
        if (rnd > 0) begin
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
          for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (rnd < 10) begin
              al = a0 ^ a1 ^ a2 ^ a3;
              s[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
              s[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
              s[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
              s[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
            end else begin
              s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
            end
          end
        end
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) s[4*c+r] ^= rk[4*rnd+c][31-8*r -: 8];
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
      return o;
    endfunction

    function logic [127:0] gf_double(logic [127:0] a);
      return {a[126:0], 1'b0} ^ {120'h0, (a[127] ? 8'h87 : 8'h00)};
    endfunction

    function void derive_subkeys();
      logic [31:0] w;
      rk[0] = key_hi[63:32]; rk[1] = key_hi[31:0];
      rk[2] = key_lo[63:32]; rk[3] = key_lo[31:0];
      for (int i = 4; i < 44; i++) begin
        w = rk[i-1];
        if (i % 4 == 0)
          w = {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]} ^
              {rcon(4'(i/4)), 24'h0};
        rk[i] = rk[i-4] ^ w;
      end
      k1 = gf_double(aes_block_enc('0));
      k2 = gf_double(k1);
      derived = 1;
    endfunction

    function void absorb();
      chain = aes_block_enc(chain ^ buffer);
      buffer = '0;
      fill = 0;
    endfunction

    // Called on every accepted chunk; queues a tag on a last chunk.
    function void note_chunk(in_t c);
      int unsigned n;
      logic [63:0] mask;
      n = c.last ? ((c.byte_count > 8) ? 8 : c.byte_count) : 8;
      if (fill == 0 && !derived) derive_subkeys();
      if (fill >= 16 && (n > 0 || !c.last)) absorb();
      if (n > 0) begin
        mask = (n >= 8) ? '1 : ~(64'hffff_ffff_ffff_ffff >> (8*n));
        if (fill >= 8) buffer[63:0] = c.data_word & mask;
        else buffer[127:64] = c.data_word & mask;
        fill += n;
      end
      if (!c.last) return;
      if (fill >= 16) buffer ^= k1;
      else begin
        buffer[127-8*fill -: 8] = buffer[127-8*fill -: 8] | PAD_BYTE;
        buffer ^= k2;
      end
      absorb();
      pending_tags.push_back(chain);
      chain = '0;
    endfunction

    function void check_tag(out_t got);
      logic [127:0] want;
      if (pending_tags.size() == 0) begin
        $error("tag transfer with none expected: %h_%h", got.mac_high, got.mac_low);
        errors++;
        return;
      end
      want = pending_tags.pop_front();
      if (got.mac_high !== want[127:64]) begin
        $error("mac_high: expected %h actual %h", want[127:64], got.mac_high);
        errors++;
      end
      if (got.mac_low !== want[63:0]) begin
        $error("mac_low: expected %h actual %h", want[63:0], got.mac_low);
        errors++;
      end
    endfunction
  endclass

  localparam int NUM_RANDOM = 800;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o, out_ready_i;
  out_t        out_data_o;

  tag_scoreboard sb;
  bit            long_hold;    // receiver holds off while set
  int            idle_cycles;

  aes128_cmac_engine_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Write one key half once the block has gone idle with no chunk offered.
  task automatic cfg_write(logic [0:0] idx, logic [63:0] val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.write_key(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one chunk and hold it until the transfer; valid stays up for
  // back-to-back chunks, the caller lowers it between bursts.
  task automatic send_chunk(logic [63:0] data, logic [3:0] cnt, logic lst);
    in_t c;
    c.data_word = data; c.byte_count = cnt; c.last = lst;
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_chunk(c);
  endtask

  task automatic gap(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Wait for all tags, then let any absorb still in flight finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_tags.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random message of mostly short length; count sometimes above eight on the last chunk.
  task automatic send_message(int burst_gap);
    int nchunks;
    nchunks = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
    for (int i = 0; i < nchunks; i++) begin
      send_chunk({$urandom, $urandom}, 4'($urandom), 1'b0);
      if (burst_gap && $urandom_range(0, 3) == 0) gap($urandom_range(1, 8));
    end
    send_chunk({$urandom, $urandom}, ($urandom_range(0, 4) == 0) ? 4'($urandom) :
               4'($urandom_range(0, 8)), 1'b1);
    if (burst_gap && $urandom_range(0, 2) == 0) gap($urandom_range(1, 12));
  endtask

  // Receiver: random stall pattern and one long hold.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) out_ready_i <= 1'b0;
      else if (($urandom_range(0, 199) < 100) && ($urandom_range(0, 3) != 0))
        out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 2) != 0);
    end
  end

  // Tag checking on each output transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_tag(out_data_o);
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering.
  task automatic hold_receiver(int n);
    long_hold = 1;
    repeat (n) @(posedge clk_i);
    long_hold = 0;
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    long_hold   = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all-zero key first (reset value), then all-ones and RFC 4493 key.
    send_chunk('0, 4'd0, 1'b1);                       // empty message
    send_chunk('1, 4'd8, 1'b1);                       // one full half-block
    send_chunk('1, 4'd0, 1'b0);                       // non-last count ignored
    send_chunk(64'h0123_4567_89ab_cdef, 4'd8, 1'b1);  // exactly one full block -> K1
    drain();
    cfg_write(REG_KEY_HIGH, '1);
    cfg_write(REG_KEY_LOW, '1);
    send_chunk('1, 4'd1, 1'b1);
    send_chunk('1, 4'd15, 1'b1);                      // count above eight saturates
    drain();
    cfg_write(REG_KEY_HIGH, 64'h2b7e_1516_28ae_d2a6);
    cfg_write(REG_KEY_LOW, 64'habf7_1588_09cf_4f3c);
    send_chunk(64'h6bc1_bee2_2e40_9f96, 4'd8, 1'b0);
    send_chunk(64'he93d_7e11_7393_172a, 4'd8, 1'b0);
    send_chunk('0, 4'd0, 1'b1);                       // empty final chunk after full block
    send_chunk(64'hae2d_8a57_1e03_ac9c, 4'd7, 1'b1);  // bytes beyond count masked
    // Key change inside a message: the running message keeps its keys.
    send_chunk(64'h1111_2222_3333_4444, 4'd8, 1'b0);
    cfg_write(REG_KEY_LOW, 64'h0);
    send_chunk(64'h5555_6666_7777_8888, 4'd8, 1'b0);
    send_chunk(64'h9999_aaaa_bbbb_cccc, 4'd3, 1'b1);
    send_chunk(64'hdead_beef_0000_ffff, 4'd4, 1'b1);  // new key takes effect
    drain();

    // Random phases with fresh keys; receiver long hold-off in one of them.
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_KEY_HIGH, {$urandom, $urandom});
      if (ph != 3) cfg_write(REG_KEY_LOW, {$urandom, $urandom});
      fork
        if (ph == 2) hold_receiver(2000);
      join_none
      for (int m = 0; m < NUM_RANDOM / 30; m++) send_message(ph != 5);
      drain();  // sender pauses until every tag has come
    end

    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
